>>> src/qau_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// operation and status codes shared by the quaternion arithmetic unit
// ----------------------------------------------------------------------------
package qau_pkg;

    localparam int OP_W  = 4;
    localparam int ERR_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ADD       = 4'd0,
        OP_SUB       = 4'd1,
        OP_MULTIPLY  = 4'd2,
        OP_SCALE     = 4'd3,
        OP_DIVIDE    = 4'd4,
        OP_CONJUGATE = 4'd5,
        OP_NORM      = 4'd6,
        OP_NORMALIZE = 4'd7,
        OP_INVERSE   = 4'd8
    } op_t;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ZERO_QUAT = 2'd2;

endpackage

>>> src/qau_sqrt_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_sqrt_pipe
// pipelined integer square root, one root bit per stage, floor result
// ----------------------------------------------------------------------------
module qau_sqrt_pipe #(
    parameter int RAD_W  = 65,
    parameter int ROOT_W = 33
) (
    input  logic              clk,
    input  logic              en,
    input  logic [RAD_W-1:0]  rad,
    output logic [ROOT_W-1:0] root
);

    localparam int TW = RAD_W + 2;

    logic [RAD_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
        localparam int B = ROOT_W - 1 - i;
        logic [RAD_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [ROOT_W-1:0] root_next;
        logic [RAD_W-1:0]  rem_next;
        logic [TW-1:0]     trial;
        logic [TW-1:0]     diff;
        logic              take;

        if (i == 0) begin : g_first
            assign rem_prev  = rad;
            assign root_prev = '0;
        end
        else begin : g_rest
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
        end

        // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
        assign trial = (TW'(root_prev) << (B + 1)) | (TW'(1) << (2 * B));
        assign take  = TW'(rem_prev) >= trial;
        assign diff  = TW'(rem_prev) - trial;

        always_comb
        begin
            root_next    = root_prev;
            root_next[B] = take;
            rem_next     = take ? diff[RAD_W-1:0] : rem_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign root = root_reg[ROOT_W-1];

endmodule

>>> src/qau_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_div_pipe
// pipelined unsigned restoring divider with a range check on the quotient
// ----------------------------------------------------------------------------
module qau_div_pipe #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 65,
    parameter int QUO_W = 33
) (
    input  logic             clk,
    input  logic             en,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic             neg_in,
    output logic [QUO_W-1:0] quo,
    output logic             neg_out,
    output logic             big_out
);

    localparam int RW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [NUM_W-1:0] rem_reg [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [QUO_W-1:0] quo_reg [QUO_W+1];
    logic             neg_reg [QUO_W+1];
    logic             big_reg [QUO_W+1];

    // quotient does not fit when num >= den * 2^QUO_W (also catches den zero)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            neg_reg[0] <= neg_in;
            big_reg[0] <= RW'(num) >= (RW'(den) << QUO_W);
        end
    end

    for (genvar i = 1; i <= QUO_W; i++) begin : g_step
        localparam int SH = QUO_W - i;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    diff;
        logic             take;
        logic [QUO_W-1:0] quo_next;

        assign trial = RW'(den_reg[i-1]) << SH;
        assign take  = RW'(rem_reg[i-1]) >= trial;
        assign diff  = RW'(rem_reg[i-1]) - trial;

        always_comb
        begin
            quo_next     = quo_reg[i-1];
            quo_next[SH] = take;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? diff[NUM_W-1:0] : rem_reg[i-1];
                den_reg[i] <= den_reg[i-1];
                quo_reg[i] <= quo_next;
                neg_reg[i] <= neg_reg[i-1];
                big_reg[i] <= big_reg[i-1];
            end
        end
    end

    assign quo     = quo_reg[QUO_W];
    assign neg_out = neg_reg[QUO_W];
    assign big_out = big_reg[QUO_W];

endmodule

>>> src/quaternion_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// fixed-point quaternion alu: add, sub, hamilton product, scale, divide,
// conjugate, norm, normalize and inverse with saturation
// ----------------------------------------------------------------------------
// Fully pipelined: one item may enter every clock cycle and one result leaves
// every cycle while out_ready is high. The pipeline stages are, in order,
// the input register, the multiplier stage, the summing stage, COMP_WIDTH+1
// square-root stages (one root bit each), COMP_WIDTH+2 divider stages
// (range check, then one quotient bit each) and the output register.
// The latency is set by the bit-serial square root and divider chains, which
// every item passes through whatever its operation. The whole pipe advances
// when the output register is empty or being taken, so a stall freezes every
// stage in place and nothing is lost or repeated. Components are signed with
// FRAC_BITS fraction bits; products round toward minus infinity, quotients
// toward zero, the norm is the floor of the exact root. Every component
// saturates to the COMP_WIDTH range and sets overflowed. A zero divisor or a
// zero quaternion for normalize or inverse gives zero components and an
// error code. Unknown operation codes give zeros with no error.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit #(
    parameter int COMP_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input item channel
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [qau_pkg::OP_W-1:0]     operation,
    input  logic signed [COMP_WIDTH-1:0] a_w,
    input  logic signed [COMP_WIDTH-1:0] a_x,
    input  logic signed [COMP_WIDTH-1:0] a_y,
    input  logic signed [COMP_WIDTH-1:0] a_z,
    input  logic signed [COMP_WIDTH-1:0] b_w,
    input  logic signed [COMP_WIDTH-1:0] b_x,
    input  logic signed [COMP_WIDTH-1:0] b_y,
    input  logic signed [COMP_WIDTH-1:0] b_z,
    input  logic signed [COMP_WIDTH-1:0] scalar,
    // result item channel
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [COMP_WIDTH-1:0] res_w,
    output logic signed [COMP_WIDTH-1:0] res_x,
    output logic signed [COMP_WIDTH-1:0] res_y,
    output logic signed [COMP_WIDTH-1:0] res_z,
    output logic [COMP_WIDTH-2:0]        norm_value,
    output logic [qau_pkg::ERR_W-1:0]    error_code,
    output logic                         overflowed
);

    localparam int CW   = COMP_WIDTH;
    localparam int FB   = FRAC_BITS;
    localparam int PW   = 2 * CW;          // one product
    localparam int W2   = 2 * CW + 2;      // sum of four products
    localparam int SW   = 2 * CW + 1;      // sum of squares
    localparam int RT   = CW + 1;          // root width
    localparam int NW   = CW + 2 * FB;     // divider numerator
    localparam int QW   = CW + 1;          // quotient bits kept
    localparam int SQD  = RT;              // square-root pipe depth
    localparam int DVD  = QW + 1;          // divider pipe depth

    localparam logic signed [W2-1:0] SAT_MAX = {{(W2-CW+1){1'b0}}, {(CW-1){1'b1}}};
    localparam logic signed [W2-1:0] SAT_MIN = {{(W2-CW+1){1'b1}}, {(CW-1){1'b0}}};
    localparam logic [CW-1:0]        C_MAX   = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0]        C_MIN   = {1'b1, {(CW-1){1'b0}}};
    localparam logic [QW-1:0]        Q_MAX   = {2'b00, {(CW-1){1'b1}}};
    localparam logic [QW-1:0]        Q_HALF  = {2'b01, {(CW-1){1'b0}}};

    // side data riding alongside the square root
    typedef struct packed {
        logic [qau_pkg::OP_W-1:0] op;
        logic [3:0][CW-1:0]       a;
        logic [CW-1:0]            s;
        logic [SW-1:0]            sumsq;
        logic [3:0][CW-1:0]       dir;
        logic                     dir_ovf;
    } sq_side_t;

    // side data riding alongside the divider
    typedef struct packed {
        logic [qau_pkg::OP_W-1:0]  op;
        logic [3:0][CW-1:0]        dir;
        logic                      dir_ovf;
        logic [qau_pkg::ERR_W-1:0] err;
        logic [CW-2:0]             normv;
    } dv_side_t;

    function automatic logic signed [W2-1:0] sx(input logic [CW-1:0] v);
        sx = {{(W2-CW){v[CW-1]}}, v};
    endfunction

    function automatic logic signed [W2-1:0] px(input logic [PW-1:0] v);
        px = {{(W2-PW){v[PW-1]}}, v};
    endfunction

    // global advance: the pipe moves when the output slot is free or taken
    logic out_valid_reg;
    logic en;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // ------------------------------------------------------------------
    // stage 0: input register
    // ------------------------------------------------------------------
    logic                         v0_reg;
    logic [qau_pkg::OP_W-1:0]     op0_reg;
    logic signed [CW-1:0]         a0_reg [4];
    logic signed [CW-1:0]         b0_reg [4];
    logic signed [CW-1:0]         s0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op0_reg   <= operation;
            a0_reg[0] <= a_w;
            a0_reg[1] <= a_x;
            a0_reg[2] <= a_y;
            a0_reg[3] <= a_z;
            b0_reg[0] <= b_w;
            b0_reg[1] <= b_x;
            b0_reg[2] <= b_y;
            b0_reg[3] <= b_z;
            s0_reg    <= scalar;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: all products (hamilton terms, squares, scale)
    // ------------------------------------------------------------------
    logic                         v1_reg;
    logic [qau_pkg::OP_W-1:0]     op1_reg;
    logic signed [CW-1:0]         a1_reg [4];
    logic signed [CW-1:0]         b1_reg [4];
    logic signed [PW-1:0]         p1_reg [16];
    logic [PW-2:0]                sq1_reg [4];
    logic signed [PW-1:0]         sc1_reg [4];

    logic signed [PW-1:0]         p_next  [16];
    logic signed [PW-1:0]         sqp     [4];
    logic signed [PW-1:0]         sc_next [4];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int j = 0; j < 4; j++)
            begin
                p_next[i*4+j] = a0_reg[i] * b0_reg[j];
            end
            sqp[i]     = a0_reg[i] * a0_reg[i];
            sc_next[i] = a0_reg[i] * s0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op1_reg <= op0_reg;
            for (int i = 0; i < 4; i++)
            begin
                a1_reg[i]  <= a0_reg[i];
                b1_reg[i]  <= b0_reg[i];
                sq1_reg[i] <= sqp[i][PW-2:0];   // square is never negative
                sc1_reg[i] <= sc_next[i];
            end
            for (int k = 0; k < 16; k++)
            begin
                p1_reg[k] <= p_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sums, rounding shifts, direct results before saturation
    // ------------------------------------------------------------------
    logic                         v2_reg;
    logic [qau_pkg::OP_W-1:0]     op2_reg;
    logic signed [CW-1:0]         a2_reg [4];
    logic signed [CW-1:0]         s2_reg;
    logic [SW-1:0]                ss2_reg;
    logic signed [W2-1:0]         dp2_reg [4];
    logic signed [CW-1:0]         s1_reg;

    logic signed [W2-1:0]         hm [4];
    logic signed [W2-1:0]         dp_next [4];
    logic [SW-1:0]                ss_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg <= s0_reg;
        end
    end

    always_comb
    begin
        // hamilton product, p[i*4+j] = a_i * b_j
        hm[0] = px(p1_reg[0])  - px(p1_reg[5])  - px(p1_reg[10]) - px(p1_reg[15]);
        hm[1] = px(p1_reg[1])  + px(p1_reg[4])  + px(p1_reg[11]) - px(p1_reg[14]);
        hm[2] = px(p1_reg[2])  - px(p1_reg[7])  + px(p1_reg[8])  + px(p1_reg[13]);
        hm[3] = px(p1_reg[3])  + px(p1_reg[6])  - px(p1_reg[9])  + px(p1_reg[12]);

        ss_next = SW'({1'b0, sq1_reg[0]}) + SW'({1'b0, sq1_reg[1]})
                + SW'({1'b0, sq1_reg[2]}) + SW'({1'b0, sq1_reg[3]});

        for (int i = 0; i < 4; i++)
        begin
            unique case (op1_reg)
                qau_pkg::OP_ADD:       dp_next[i] = sx(a1_reg[i]) + sx(b1_reg[i]);
                qau_pkg::OP_SUB:       dp_next[i] = sx(a1_reg[i]) - sx(b1_reg[i]);
                qau_pkg::OP_MULTIPLY:  dp_next[i] = hm[i] >>> FB;
                qau_pkg::OP_SCALE:     dp_next[i] = px(sc1_reg[i]) >>> FB;
                qau_pkg::OP_CONJUGATE: dp_next[i] = (i == 0) ? sx(a1_reg[i])
                                                             : -sx(a1_reg[i]);
                default:               dp_next[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op2_reg <= op1_reg;
            s2_reg  <= s1_reg;
            ss2_reg <= ss_next;
            for (int i = 0; i < 4; i++)
            begin
                a2_reg[i]  <= a1_reg[i];
                dp2_reg[i] <= dp_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // square root of the sum of squares, direct results saturated on entry
    // ------------------------------------------------------------------
    sq_side_t              sq_in;
    sq_side_t              sq_side_reg [SQD];
    logic [SQD-1:0]        vsq_reg;
    logic [RT-1:0]         root;

    always_comb
    begin
        sq_in.op      = op2_reg;
        sq_in.s       = s2_reg;
        sq_in.sumsq   = ss2_reg;
        sq_in.dir_ovf = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            sq_in.a[i] = a2_reg[i];
            if (dp2_reg[i] > SAT_MAX)
            begin
                sq_in.dir[i]  = C_MAX;
                sq_in.dir_ovf = 1'b1;
            end
            else if (dp2_reg[i] < SAT_MIN)
            begin
                sq_in.dir[i]  = C_MIN;
                sq_in.dir_ovf = 1'b1;
            end
            else
            begin
                sq_in.dir[i] = dp2_reg[i][CW-1:0];
            end
        end
    end

    qau_sqrt_pipe #(
        .RAD_W  (SW),
        .ROOT_W (RT)
    ) u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (ss2_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_side_reg[0] <= sq_in;
            for (int k = 1; k < SQD; k++)
            begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // divider setup: numerator, divisor and sign per lane, error code
    // ------------------------------------------------------------------
    sq_side_t                   sq_out;
    dv_side_t                   dv_in;
    dv_side_t                   dv_side_reg [DVD];
    logic [DVD-1:0]             vdv_reg;
    logic [CW-1:0]              mag_a [4];
    logic [CW-1:0]              mag_s;
    logic [NW-1:0]              div_num [4];
    logic [SW-1:0]              div_den;
    logic                       div_neg [4];
    logic [QW-1:0]              quo [4];
    logic                       quo_neg [4];
    logic                       quo_big [4];

    assign sq_out = sq_side_reg[SQD-1];

    always_comb
    begin
        mag_s = sq_out.s[CW-1] ? (~sq_out.s + CW'(1)) : sq_out.s;
        for (int i = 0; i < 4; i++)
        begin
            mag_a[i] = sq_out.a[i][CW-1] ? (~sq_out.a[i] + CW'(1)) : sq_out.a[i];
        end

        dv_in.op      = sq_out.op;
        dv_in.dir     = sq_out.dir;
        dv_in.dir_ovf = sq_out.dir_ovf;
        dv_in.err     = qau_pkg::ERR_NONE;
        // norm saturates without touching overflowed
        dv_in.normv   = (root[RT-1] || root[RT-2]) ? {(CW-1){1'b1}} : root[CW-2:0];

        div_den = '0;
        for (int i = 0; i < 4; i++)
        begin
            div_num[i] = '0;
            div_neg[i] = 1'b0;
        end

        unique case (sq_out.op)
            qau_pkg::OP_DIVIDE:
            begin
                div_den = SW'(mag_s);
                for (int i = 0; i < 4; i++)
                begin
                    div_num[i] = NW'(mag_a[i]) << FB;
                    div_neg[i] = sq_out.a[i][CW-1] ^ sq_out.s[CW-1];
                end
                if (sq_out.s == '0)
                begin
                    dv_in.err = qau_pkg::ERR_DIV_ZERO;
                end
            end
            qau_pkg::OP_NORMALIZE:
            begin
                div_den = SW'(root);
                for (int i = 0; i < 4; i++)
                begin
                    div_num[i] = NW'(mag_a[i]) << FB;
                    div_neg[i] = sq_out.a[i][CW-1];
                end
                if (sq_out.sumsq == '0)
                begin
                    dv_in.err = qau_pkg::ERR_ZERO_QUAT;
                end
            end
            qau_pkg::OP_INVERSE:
            begin
                // conjugate over the squared norm; vector lanes flip sign
                div_den = sq_out.sumsq;
                for (int i = 0; i < 4; i++)
                begin
                    div_num[i] = NW'(mag_a[i]) << (2 * FB);
                    div_neg[i] = (i == 0) ? sq_out.a[i][CW-1] : !sq_out.a[i][CW-1];
                end
                if (sq_out.sumsq == '0)
                begin
                    dv_in.err = qau_pkg::ERR_ZERO_QUAT;
                end
            end
            default:
            begin
                div_den = '0;
            end
        endcase
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        qau_div_pipe #(
            .NUM_W (NW),
            .DEN_W (SW),
            .QUO_W (QW)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .num     (div_num[g]),
            .den     (div_den),
            .neg_in  (div_neg[g]),
            .quo     (quo[g]),
            .neg_out (quo_neg[g]),
            .big_out (quo_big[g])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_side_reg[0] <= dv_in;
            for (int k = 1; k < DVD; k++)
            begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // item valid bits, shifted with the data
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            vsq_reg <= '0;
            vdv_reg <= '0;
        end
        else if (en)
        begin
            v0_reg  <= in_valid;
            v1_reg  <= v0_reg;
            v2_reg  <= v1_reg;
            vsq_reg <= {vsq_reg[SQD-2:0], v2_reg};
            vdv_reg <= {vdv_reg[DVD-2:0], vsq_reg[SQD-1]};
        end
    end

    // ------------------------------------------------------------------
    // final select: quotient saturation and result mux
    // ------------------------------------------------------------------
    dv_side_t                  dv_out;
    logic [CW-1:0]             qv [4];
    logic                      qovf [4];
    logic [CW-1:0]             res_next [4];
    logic                      ovf_next;

    assign dv_out = dv_side_reg[DVD-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            qovf[i] = 1'b0;
            if (quo_big[i])
            begin
                qovf[i] = 1'b1;
                qv[i]   = quo_neg[i] ? C_MIN : C_MAX;
            end
            else if (quo_neg[i])
            begin
                if (quo[i] > Q_HALF)
                begin
                    qovf[i] = 1'b1;
                    qv[i]   = C_MIN;
                end
                else
                begin
                    qv[i] = ~quo[i][CW-1:0] + CW'(1);
                end
            end
            else if (quo[i] > Q_MAX)
            begin
                qovf[i] = 1'b1;
                qv[i]   = C_MAX;
            end
            else
            begin
                qv[i] = quo[i][CW-1:0];
            end
        end

        ovf_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            res_next[i] = '0;
        end

        unique case (dv_out.op)
            qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_MULTIPLY,
            qau_pkg::OP_SCALE, qau_pkg::OP_CONJUGATE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    res_next[i] = dv_out.dir[i];
                end
                ovf_next = dv_out.dir_ovf;
            end
            qau_pkg::OP_DIVIDE, qau_pkg::OP_NORMALIZE, qau_pkg::OP_INVERSE:
            begin
                if (dv_out.err == qau_pkg::ERR_NONE)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        res_next[i] = qv[i];
                    end
                    ovf_next = qovf[0] | qovf[1] | qovf[2] | qovf[3];
                end
            end
            default:
            begin
                ovf_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [CW-1:0]             res_reg [4];
    logic [CW-2:0]             norm_reg;
    logic [qau_pkg::ERR_W-1:0] err_reg;
    logic                      ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= vdv_reg[DVD-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            norm_reg <= dv_out.normv;
            err_reg  <= dv_out.err;
            ovf_reg  <= ovf_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign res_w      = res_reg[0];
    assign res_x      = res_reg[1];
    assign res_y      = res_reg[2];
    assign res_z      = res_reg[3];
    assign norm_value = norm_reg;
    assign error_code = err_reg;
    assign overflowed = ovf_reg;

endmodule
